@@ hdl/ieeseq_pkg.sv @@
// types and constants shared by the eeprom transaction sequencer
// no dependencies; imported by every module of the block
`default_nettype none

package ieeseq_pkg;

    // request and response command codes
    localparam logic [2:0] CMD_READ_REQ  = 3'd0;
    localparam logic [2:0] CMD_WRITE_REQ = 3'd1;
    localparam logic [2:0] CMD_ACK_RESP  = 3'd2;
    localparam logic [2:0] CMD_RX_BYTE   = 3'd3;
    localparam logic [2:0] CMD_WR_DATA   = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_CONTROL_BYTE = 2'd0;
    localparam logic [1:0] CFG_ADDR_BYTES   = 2'd1;
    localparam logic [1:0] CFG_PAGE_LOG2    = 2'd2;
    localparam logic [1:0] CFG_POLL_LIMIT   = 2'd3;

    localparam logic [7:0]  RST_CONTROL_BYTE = 8'hA0;
    localparam logic [1:0]  RST_ADDR_BYTES   = 2'd2;
    localparam logic [3:0]  RST_PAGE_LOG2    = 4'd7;
    localparam logic [15:0] RST_POLL_LIMIT   = 16'd1000;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_ACK  = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    localparam int unsigned GROUP_MAX = 4;

    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_STOP  = 3'd1,
        OP_SEND  = 3'd2,
        OP_READ  = 3'd3,
        OP_ACK   = 3'd4,
        OP_NACK  = 3'd5,
        OP_DATA  = 3'd6,
        OP_DONE  = 3'd7
    } t_bus_op;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] mem_addr;
        logic [15:0] length;
        logic [7:0]  data;
        logic        ack;
    } t_in_item;

    typedef struct packed {
        t_bus_op     bus_op;
        logic [7:0]  bus_byte;
        logic [1:0]  status;
        logic        last;
    } t_out_item;

    // one result without its last flag
    typedef struct packed {
        t_bus_op     op;
        logic [7:0]  val;
        logic [1:0]  status;
    } t_res;

    // all results caused by one input item
    typedef struct packed {
        logic [1:0]               cnt_m1;
        t_res [GROUP_MAX-1:0]     res;
    } t_group;

    function automatic t_res mk_res(t_bus_op op, logic [7:0] val, logic [1:0] status);
        t_res r;
        r.op     = op;
        r.val    = val;
        r.status = status;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/ieeseq_front.sv @@
// front part: configuration registers, transfer state machine and result grouping
// depends on ieeseq_pkg; feeds ieeseq_queue
`default_nettype none

module ieeseq_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [15:0]          i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  ieeseq_pkg::t_in_item      i_in_item,
    input  wire logic                 i_q_full,
    output logic                      o_push,
    output ieeseq_pkg::t_group        o_group
);
    import ieeseq_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE, PH_CTRL_ACK, PH_AHI_ACK, PH_ALO_ACK,
        PH_RCTRL_ACK, PH_RBYTE, PH_WBYTE, PH_WACK
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_writing, n_writing;
    logic [15:0] r_cur_addr, n_cur_addr;
    logic [15:0] r_bytes_done, n_bytes_done;
    logic [15:0] r_total, n_total;
    logic [15:0] r_poll_cnt, n_poll_cnt;

    logic [7:0]  r_ctrl;
    logic [1:0]  r_addr_bytes;
    logic [3:0]  r_page_log2;
    logic [15:0] r_poll_limit;

    logic        accept;
    logic [2:0]  cnt;
    t_res [GROUP_MAX-1:0] res;
    logic [7:0]  ctrl_w, ctrl_r;
    logic [15:0] bd_inc, addr_inc, page_mask;
    logic [1:0]  cnt_m1;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign ctrl_w     = {r_ctrl[7:1], 1'b0};
    assign ctrl_r     = {r_ctrl[7:1], 1'b1};
    assign bd_inc     = r_bytes_done + 16'd1;
    assign addr_inc   = r_cur_addr + 16'd1;
    assign page_mask  = ~(16'hFFFF << r_page_log2);
    assign cnt_m1     = 2'(cnt - 3'd1);

    always_comb begin
        n_phase      = r_phase;
        n_writing    = r_writing;
        n_cur_addr   = r_cur_addr;
        n_bytes_done = r_bytes_done;
        n_total      = r_total;
        n_poll_cnt   = r_poll_cnt;
        cnt          = 3'd0;
        for (int k = 0; k < GROUP_MAX; k++) begin
            res[k] = mk_res(OP_START, 8'd0, ST_OK);
        end
        if (accept) begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_in_item.cmd == CMD_READ_REQ || i_in_item.cmd == CMD_WRITE_REQ) begin
                        n_writing    = (i_in_item.cmd == CMD_WRITE_REQ);
                        n_cur_addr   = i_in_item.mem_addr;
                        n_total      = i_in_item.length;
                        n_bytes_done = 16'd0;
                        n_poll_cnt   = 16'd0;
                        if (i_in_item.cmd == CMD_READ_REQ) begin
                            res[0]  = mk_res(OP_START, 8'd0, ST_OK);
                            res[1]  = mk_res(OP_SEND, ctrl_w, ST_OK);
                            cnt     = 3'd2;
                            n_phase = PH_CTRL_ACK;
                        end else if (i_in_item.length == 16'd0) begin
                            res[0]  = mk_res(OP_STOP, 8'd0, ST_OK);
                            res[1]  = mk_res(OP_DONE, 8'd0, ST_OK);
                            cnt     = 3'd2;
                        end else begin
                            res[0]     = mk_res(OP_STOP, 8'd0, ST_OK);
                            res[1]     = mk_res(OP_START, 8'd0, ST_OK);
                            res[2]     = mk_res(OP_SEND, ctrl_w, ST_OK);
                            cnt        = 3'd3;
                            n_poll_cnt = 16'd1;
                            n_phase    = PH_CTRL_ACK;
                        end
                    end
                end
                PH_CTRL_ACK: begin
                    if (i_in_item.cmd == CMD_ACK_RESP) begin
                        cnt = 3'd2;
                        if (i_in_item.ack) begin
                            cnt = 3'd1;
                            if (r_addr_bytes == 2'd1) begin
                                res[0]  = mk_res(OP_SEND, r_cur_addr[7:0], ST_OK);
                                n_phase = PH_ALO_ACK;
                            end else begin
                                res[0]  = mk_res(OP_SEND, r_cur_addr[15:8], ST_OK);
                                n_phase = PH_AHI_ACK;
                            end
                        end else if (!r_writing) begin
                            res[0]  = mk_res(OP_STOP, 8'd0, ST_OK);
                            res[1]  = mk_res(OP_DONE, 8'd0, ST_NO_ACK);
                            n_phase = PH_IDLE;
                        end else if (r_poll_cnt >= r_poll_limit) begin
                            res[0]  = mk_res(OP_STOP, 8'd0, ST_OK);
                            res[1]  = mk_res(OP_DONE, 8'd0, ST_TIMEOUT);
                            n_phase = PH_IDLE;
                        end else begin
                            // another polling attempt
                            res[0]     = mk_res(OP_START, 8'd0, ST_OK);
                            res[1]     = mk_res(OP_SEND, ctrl_w, ST_OK);
                            n_poll_cnt = r_poll_cnt + 16'd1;
                        end
                    end
                end
                PH_AHI_ACK: begin
                    if (i_in_item.cmd == CMD_ACK_RESP) begin
                        if (i_in_item.ack) begin
                            res[0]  = mk_res(OP_SEND, r_cur_addr[7:0], ST_OK);
                            cnt     = 3'd1;
                            n_phase = PH_ALO_ACK;
                        end else begin
                            res[0]  = mk_res(OP_STOP, 8'd0, ST_OK);
                            res[1]  = mk_res(OP_DONE, 8'd0, ST_NO_ACK);
                            cnt     = 3'd2;
                            n_phase = PH_IDLE;
                        end
                    end
                end
                PH_ALO_ACK: begin
                    if (i_in_item.cmd == CMD_ACK_RESP) begin
                        if (!i_in_item.ack) begin
                            res[0]  = mk_res(OP_STOP, 8'd0, ST_OK);
                            res[1]  = mk_res(OP_DONE, 8'd0, ST_NO_ACK);
                            cnt     = 3'd2;
                            n_phase = PH_IDLE;
                        end else if (r_writing) begin
                            n_phase = PH_WBYTE;
                        end else begin
                            // repeated start for the read form
                            res[0]  = mk_res(OP_START, 8'd0, ST_OK);
                            res[1]  = mk_res(OP_SEND, ctrl_r, ST_OK);
                            cnt     = 3'd2;
                            n_phase = PH_RCTRL_ACK;
                        end
                    end
                end
                PH_RCTRL_ACK: begin
                    if (i_in_item.cmd == CMD_ACK_RESP) begin
                        if (!i_in_item.ack || r_total == 16'd0) begin
                            res[0]  = mk_res(OP_STOP, 8'd0, ST_OK);
                            res[1]  = mk_res(OP_DONE, 8'd0,
                                             i_in_item.ack ? ST_OK : ST_NO_ACK);
                            cnt     = 3'd2;
                            n_phase = PH_IDLE;
                        end else begin
                            res[0]  = mk_res(OP_READ, 8'd0, ST_OK);
                            cnt     = 3'd1;
                            n_phase = PH_RBYTE;
                        end
                    end
                end
                PH_RBYTE: begin
                    if (i_in_item.cmd == CMD_RX_BYTE) begin
                        res[0]       = mk_res(OP_DATA, i_in_item.data, ST_OK);
                        n_bytes_done = bd_inc;
                        if (bd_inc >= r_total) begin
                            res[1]  = mk_res(OP_NACK, 8'd0, ST_OK);
                            res[2]  = mk_res(OP_STOP, 8'd0, ST_OK);
                            res[3]  = mk_res(OP_DONE, 8'd0, ST_OK);
                            cnt     = 3'd4;
                            n_phase = PH_IDLE;
                        end else begin
                            res[1] = mk_res(OP_ACK, 8'd0, ST_OK);
                            res[2] = mk_res(OP_READ, 8'd0, ST_OK);
                            cnt    = 3'd3;
                        end
                    end
                end
                PH_WBYTE: begin
                    if (i_in_item.cmd == CMD_WR_DATA) begin
                        res[0]  = mk_res(OP_SEND, i_in_item.data, ST_OK);
                        cnt     = 3'd1;
                        n_phase = PH_WACK;
                    end
                end
                PH_WACK: begin
                    if (i_in_item.cmd == CMD_ACK_RESP) begin
                        if (!i_in_item.ack) begin
                            res[0]  = mk_res(OP_STOP, 8'd0, ST_OK);
                            res[1]  = mk_res(OP_DONE, 8'd0, ST_NO_ACK);
                            cnt     = 3'd2;
                            n_phase = PH_IDLE;
                        end else begin
                            n_bytes_done = bd_inc;
                            n_cur_addr   = addr_inc;
                            if (bd_inc >= r_total) begin
                                res[0]  = mk_res(OP_STOP, 8'd0, ST_OK);
                                res[1]  = mk_res(OP_DONE, 8'd0, ST_OK);
                                cnt     = 3'd2;
                                n_phase = PH_IDLE;
                            end else if ((addr_inc & page_mask) == 16'd0) begin
                                // page boundary: new segment with fresh polling
                                res[0]     = mk_res(OP_STOP, 8'd0, ST_OK);
                                res[1]     = mk_res(OP_START, 8'd0, ST_OK);
                                res[2]     = mk_res(OP_SEND, ctrl_w, ST_OK);
                                cnt        = 3'd3;
                                n_poll_cnt = 16'd1;
                                n_phase    = PH_CTRL_ACK;
                            end else begin
                                n_phase = PH_WBYTE;
                            end
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    assign o_push       = accept && (cnt != 3'd0);
    assign o_group.res  = res;
    assign o_group.cnt_m1 = cnt_m1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_writing    <= 1'b0;
            r_cur_addr   <= 16'd0;
            r_bytes_done <= 16'd0;
            r_total      <= 16'd0;
            r_poll_cnt   <= 16'd0;
            r_ctrl       <= RST_CONTROL_BYTE;
            r_addr_bytes <= RST_ADDR_BYTES;
            r_page_log2  <= RST_PAGE_LOG2;
            r_poll_limit <= RST_POLL_LIMIT;
        end else begin
            r_phase      <= n_phase;
            r_writing    <= n_writing;
            r_cur_addr   <= n_cur_addr;
            r_bytes_done <= n_bytes_done;
            r_total      <= n_total;
            r_poll_cnt   <= n_poll_cnt;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_CONTROL_BYTE: r_ctrl       <= i_cfg_data[7:0];
                    CFG_ADDR_BYTES:   r_addr_bytes <= i_cfg_data[1:0];
                    CFG_PAGE_LOG2:    r_page_log2  <= i_cfg_data[3:0];
                    CFG_POLL_LIMIT:   r_poll_limit <= i_cfg_data;
                    default:          r_ctrl       <= r_ctrl;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/ieeseq_queue.sv @@
// short queue of result groups between the front and back parts
// depends on ieeseq_pkg
`default_nettype none

module ieeseq_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  ieeseq_pkg::t_group i_group,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_head_valid,
    output ieeseq_pkg::t_group o_head
);
    import ieeseq_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_group             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push, do_pop;

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hdl/ieeseq_back.sv @@
// back part: unpacks each result group into single output beats
// depends on ieeseq_pkg; fed by ieeseq_queue
`default_nettype none

module ieeseq_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_head_valid,
    input  ieeseq_pkg::t_group   i_head,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output ieeseq_pkg::t_out_item o_out_item
);
    import ieeseq_pkg::*;

    logic        r_busy;
    t_group      r_grp;
    logic [1:0]  r_idx;
    logic        take, group_end;
    t_res        cur;

    assign cur         = r_grp.res[r_idx];
    assign take        = r_busy && i_out_ready;
    assign group_end   = (r_idx == r_grp.cnt_m1);
    assign o_pop       = i_head_valid && (!r_busy || (take && group_end));
    assign o_out_valid = r_busy;

    assign o_out_item.bus_op   = cur.op;
    assign o_out_item.bus_byte = cur.val;
    assign o_out_item.status   = cur.status;
    assign o_out_item.last     = group_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= 2'd0;
                r_grp  <= i_head;
            end else if (take) begin
                // group end with nothing queued leaves the back part empty
                if (group_end) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/i2c_eeprom_transaction_sequencer.sv @@
// top level of the serial eeprom transaction sequencer
// depends on ieeseq_pkg, ieeseq_front, ieeseq_queue and ieeseq_back
`default_nettype none

// Master-side sequencer for 24xx serial EEPROM transfers. Each input beat
// (request, ack response, received byte or write data byte) is taken by the
// front state machine, which turns it into a group of zero to four bus
// primitives and result beats; groups wait in a queue of QUEUE_DEPTH entries.
// Input is accepted every cycle while the queue has a free entry. The back
// part sends one result beat per cycle while the output is ready, so the
// sustained rate is set by how many results the items cause. Configuration
// writes take effect at once and should only be made while no transfer is
// in flight.
module i2c_eeprom_transaction_sequencer #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [1:0]       i_cfg_index,
    input  wire logic [15:0]      i_cfg_data,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  ieeseq_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output ieeseq_pkg::t_out_item o_out_item
);
    import ieeseq_pkg::*;

    logic   q_push, q_full, q_pop, q_head_valid;
    t_group q_in, q_head;

    ieeseq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_group     (q_in)
    );

    ieeseq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_group      (q_in),
        .o_full       (q_full),
        .i_pop        (q_pop),
        .o_head_valid (q_head_valid),
        .o_head       (q_head)
    );

    ieeseq_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_head_valid),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_item   (o_out_item)
    );

endmodule

`default_nettype wire

@@ tb/ieeseq_checker.sv @@
`timescale 1ns / 1ps
// result checker for the serial eeprom transaction sequencer
// watches config writes and both beat channels, predicts the bus primitives
// and compares them in order; depends on ieeseq_pkg only

module ieeseq_checker (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [1:0]       i_cfg_index,
    input  wire logic [15:0]      i_cfg_data,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_ready,
    input  ieeseq_pkg::t_in_item  i_in_item,
    input  wire logic             i_out_valid,
    input  wire logic             i_out_ready,
    input  ieeseq_pkg::t_out_item i_out_item,
    output int                    o_fail_count,
    output int                    o_pending
);
    import ieeseq_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_CTRL_ACK,
        PH_AHI_ACK,
        PH_ALO_ACK,
        PH_RCTRL_ACK,
        PH_RBYTE,
        PH_WBYTE,
        PH_WACK
    } t_seq_phase;

    // register copies
    logic [7:0]  ctrl_byte;
    logic [1:0]  addr_bytes;
    logic [3:0]  page_log2;
    logic [15:0] poll_lim;

    // transfer state
    t_seq_phase  seq_phase;
    logic        is_write;
    logic [15:0] cur_addr;
    logic [15:0] done_cnt;
    logic [15:0] total_cnt;
    logic [15:0] poll_cnt;

    t_out_item   expected_beats[$];
    t_out_item   burst[GROUP_MAX];
    int          burst_n;
    t_out_item   got;
    t_out_item   want;
    int          beat_idx   = 0;
    int          fail_count = 0;
    int          pending_n  = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_n;

    task automatic report(string msg);
        $display("error: result beat %0d at %0t: %s", beat_idx, $realtime, msg);
        fail_count++;
    endtask

    task automatic push_op(t_bus_op op, logic [7:0] b, logic [1:0] st);
        t_out_item r;
        r.bus_op   = op;
        r.bus_byte = b;
        r.status   = st;
        r.last     = 1'b0;
        burst[burst_n] = r;
        burst_n++;
    endtask

    task automatic close_xfer(logic [1:0] st);
        push_op(OP_STOP, 8'h00, ST_OK);
        push_op(OP_DONE, 8'h00, st);
        seq_phase = PH_IDLE;
    endtask

    task automatic poll_try();
        push_op(OP_START, 8'h00, ST_OK);
        push_op(OP_SEND, ctrl_byte & 8'hFE, ST_OK);
        poll_cnt  = poll_cnt + 16'd1;
        seq_phase = PH_CTRL_ACK;
    endtask

    task automatic send_addr();
        if (addr_bytes == 2'd1) begin
            push_op(OP_SEND, cur_addr[7:0], ST_OK);
            seq_phase = PH_ALO_ACK;
        end else begin
            push_op(OP_SEND, cur_addr[15:8], ST_OK);
            seq_phase = PH_AHI_ACK;
        end
    endtask

    task automatic predict(t_in_item it);
        logic [15:0] page_mask;
        t_out_item   r;
        page_mask = 16'((32'd1 << page_log2) - 32'd1);
        burst_n   = 0;
        case (seq_phase)
            PH_IDLE: begin
                if (it.cmd == CMD_READ_REQ || it.cmd == CMD_WRITE_REQ) begin
                    is_write  = (it.cmd == CMD_WRITE_REQ);
                    cur_addr  = it.mem_addr;
                    total_cnt = it.length;
                    done_cnt  = '0;
                    poll_cnt  = '0;
                    if (!is_write) begin
                        push_op(OP_START, 8'h00, ST_OK);
                        push_op(OP_SEND, ctrl_byte & 8'hFE, ST_OK);
                        seq_phase = PH_CTRL_ACK;
                    end else if (it.length == 16'd0) begin
                        close_xfer(ST_OK);
                    end else begin
                        push_op(OP_STOP, 8'h00, ST_OK);
                        poll_try();
                    end
                end
            end
            PH_CTRL_ACK: begin
                if (it.cmd == CMD_ACK_RESP) begin
                    if (it.ack) send_addr();
                    else if (!is_write) close_xfer(ST_NO_ACK);
                    else if (poll_cnt >= poll_lim) close_xfer(ST_TIMEOUT);
                    else poll_try();
                end
            end
            PH_AHI_ACK: begin
                if (it.cmd == CMD_ACK_RESP) begin
                    if (!it.ack) begin
                        close_xfer(ST_NO_ACK);
                    end else begin
                        push_op(OP_SEND, cur_addr[7:0], ST_OK);
                        seq_phase = PH_ALO_ACK;
                    end
                end
            end
            PH_ALO_ACK: begin
                if (it.cmd == CMD_ACK_RESP) begin
                    if (!it.ack) begin
                        close_xfer(ST_NO_ACK);
                    end else if (is_write) begin
                        seq_phase = PH_WBYTE;
                    end else begin
                        // repeated start with the read form of the control byte
                        push_op(OP_START, 8'h00, ST_OK);
                        push_op(OP_SEND, ctrl_byte | 8'h01, ST_OK);
                        seq_phase = PH_RCTRL_ACK;
                    end
                end
            end
            PH_RCTRL_ACK: begin
                if (it.cmd == CMD_ACK_RESP) begin
                    if (!it.ack) begin
                        close_xfer(ST_NO_ACK);
                    end else if (total_cnt == 16'd0) begin
                        close_xfer(ST_OK);
                    end else begin
                        push_op(OP_READ, 8'h00, ST_OK);
                        seq_phase = PH_RBYTE;
                    end
                end
            end
            PH_RBYTE: begin
                if (it.cmd == CMD_RX_BYTE) begin
                    push_op(OP_DATA, it.data, ST_OK);
                    done_cnt = done_cnt + 16'd1;
                    if (done_cnt >= total_cnt) begin
                        push_op(OP_NACK, 8'h00, ST_OK);
                        close_xfer(ST_OK);
                    end else begin
                        push_op(OP_ACK, 8'h00, ST_OK);
                        push_op(OP_READ, 8'h00, ST_OK);
                    end
                end
            end
            PH_WBYTE: begin
                if (it.cmd == CMD_WR_DATA) begin
                    push_op(OP_SEND, it.data, ST_OK);
                    seq_phase = PH_WACK;
                end
            end
            PH_WACK: begin
                if (it.cmd == CMD_ACK_RESP) begin
                    if (!it.ack) begin
                        close_xfer(ST_NO_ACK);
                    end else begin
                        done_cnt = done_cnt + 16'd1;
                        cur_addr = cur_addr + 16'd1;
                        if (done_cnt >= total_cnt) begin
                            close_xfer(ST_OK);
                        end else if ((cur_addr & page_mask) == 16'd0) begin
                            // page boundary: new segment with fresh polling
                            poll_cnt = '0;
                            push_op(OP_STOP, 8'h00, ST_OK);
                            poll_try();
                        end else begin
                            seq_phase = PH_WBYTE;
                        end
                    end
                end
            end
            default: seq_phase = PH_IDLE;
        endcase
        for (int k = 0; k < burst_n; k++) begin
            r      = burst[k];
            r.last = (k == burst_n - 1);
            expected_beats.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ctrl_byte  = RST_CONTROL_BYTE;
            addr_bytes = RST_ADDR_BYTES;
            page_log2  = RST_PAGE_LOG2;
            poll_lim   = RST_POLL_LIMIT;
            seq_phase  = PH_IDLE;
            is_write   = 1'b0;
            cur_addr   = '0;
            done_cnt   = '0;
            total_cnt  = '0;
            poll_cnt   = '0;
            expected_beats.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_CONTROL_BYTE: ctrl_byte  = i_cfg_data[7:0];
                    CFG_ADDR_BYTES:   addr_bytes = i_cfg_data[1:0];
                    CFG_PAGE_LOG2:    page_log2  = i_cfg_data[3:0];
                    CFG_POLL_LIMIT:   poll_lim   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got = i_out_item;
                if (expected_beats.size() == 0) begin
                    report($sformatf("unexpected beat op %0d byte %02h", got.bus_op,
                                     got.bus_byte));
                end else begin
                    want = expected_beats.pop_front();
                    if (got.bus_op !== want.bus_op)
                        report($sformatf("bus_op %0d, want %0d", got.bus_op, want.bus_op));
                    if (got.bus_byte !== want.bus_byte)
                        report($sformatf("bus_byte %02h, want %02h", got.bus_byte,
                                         want.bus_byte));
                    if (got.status !== want.status)
                        report($sformatf("status %0d, want %0d", got.status, want.status));
                    if (got.last !== want.last)
                        report($sformatf("last %0b, want %0b", got.last, want.last));
                end
                beat_idx++;
            end
            if (i_in_valid && i_in_ready)
                predict(i_in_item);
        end
        pending_n = expected_beats.size();
    end

endmodule

@@ tb/tb_i2c_eeprom_transaction_sequencer.sv @@
`timescale 1ns / 1ps
// top of the eeprom sequencer testbench: clock, reset, config and request beats
// drives i2c_eeprom_transaction_sequencer, checking is done by ieeseq_checker

module tb_i2c_eeprom_transaction_sequencer;
    import ieeseq_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_BEATS  = 180;
    localparam int PHASE_BEATS   = 36;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    t_in_item    in_item   = '0;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    t_out_item   out_item;
    int          fails;
    int          pending;

    // stimulus knobs and register mirrors
    bit          calm       = 1'b0;
    int          noise_pct  = 0;
    int          real_beats = 0;
    logic [1:0]  cfg_abytes = RST_ADDR_BYTES;
    logic [3:0]  cfg_plog2  = RST_PAGE_LOG2;
    logic [15:0] cfg_plimit = RST_POLL_LIMIT;

    i2c_eeprom_transaction_sequencer u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    ieeseq_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_fail_count (fails),
        .o_pending    (pending)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(negedge clk) begin
        out_ready <= calm || ($urandom_range(0, 99) >= 23);
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic t_in_item rand_item(logic [2:0] cmd);
        t_in_item it;
        it.cmd      = cmd;
        it.mem_addr = 16'($urandom);
        it.length   = 16'($urandom);
        it.data     = 8'($urandom);
        it.ack      = 1'($urandom);
        return it;
    endfunction

    // entered and left just after a falling edge
    task automatic send_item(t_in_item it);
        while (!calm && $urandom_range(0, 99) < 23) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // a beat the sequencer is waiting for, sometimes preceded by one it ignores
    task automatic beat(t_in_item it);
        logic [2:0] other;
        if ($urandom_range(0, 99) < noise_pct) begin
            do other = 3'($urandom);
            while (other == it.cmd ||
                   (it.cmd <= CMD_WRITE_REQ && other <= CMD_WRITE_REQ));
            send_item(rand_item(other));
        end
        send_item(it);
        real_beats++;
    endtask

    // fail_in: acks to give before the missing one, negative for none
    task automatic answer(inout int fail_in, output bit ok);
        t_in_item it;
        it     = rand_item(CMD_ACK_RESP);
        ok     = (fail_in != 0);
        it.ack = ok;
        if (fail_in > 0) fail_in--;
        beat(it);
    endtask

    task automatic settle();
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic load_config(logic [7:0] c, logic [1:0] a, logic [3:0] p, logic [15:0] l);
        logic [15:0] vals[4];
        // unused upper bits carry junk
        vals[CFG_CONTROL_BYTE] = {8'($urandom), c};
        vals[CFG_ADDR_BYTES]   = {14'($urandom), a};
        vals[CFG_PAGE_LOG2]    = {12'($urandom), p};
        vals[CFG_POLL_LIMIT]   = l;
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data  <= vals[i];
            @(negedge clk);
        end
        cfg_wr_en  <= 1'b0;
        cfg_abytes = a;
        cfg_plog2  = p;
        cfg_plimit = l;
    endtask

    task automatic do_read(logic [15:0] addr, logic [15:0] len, int fail_in);
        t_in_item it;
        bit       ok;
        int       nab;
        nab         = (cfg_abytes == 2'd1) ? 1 : 2;
        it          = rand_item(CMD_READ_REQ);
        it.mem_addr = addr;
        it.length   = len;
        beat(it);
        // control byte, address bytes, then the read form of the control byte
        repeat (nab + 2) begin
            answer(fail_in, ok);
            if (!ok) return;
        end
        repeat (len) beat(rand_item(CMD_RX_BYTE));
    endtask

    // polls: failed ack polls in the first segment; reaching the limit times out
    task automatic do_write(logic [15:0] addr, logic [15:0] len, int fail_in, int polls);
        t_in_item    it;
        bit          ok;
        int          nab;
        int          eff_lim;
        int          n;
        logic [15:0] a;
        logic [15:0] page_mask;
        nab         = (cfg_abytes == 2'd1) ? 1 : 2;
        eff_lim     = (cfg_plimit == 16'd0) ? 1 : int'(cfg_plimit);
        page_mask   = 16'((32'd1 << cfg_plog2) - 32'd1);
        it          = rand_item(CMD_WRITE_REQ);
        it.mem_addr = addr;
        it.length   = len;
        beat(it);
        if (len == 16'd0) return;
        n = 0;
        a = addr;
        forever begin
            repeat (polls) begin
                it     = rand_item(CMD_ACK_RESP);
                it.ack = 1'b0;
                beat(it);
            end
            if (polls >= eff_lim) return;
            it     = rand_item(CMD_ACK_RESP);
            it.ack = 1'b1;
            beat(it);
            repeat (nab) begin
                answer(fail_in, ok);
                if (!ok) return;
            end
            do begin
                beat(rand_item(CMD_WR_DATA));
                answer(fail_in, ok);
                if (!ok) return;
                n++;
                a = a + 16'd1;
                if (n >= int'(len)) return;
            end while ((a & page_mask) != 16'd0);
            polls = $urandom_range(0, (eff_lim > 3) ? 2 : eff_lim - 1);
        end
    endtask

    task automatic random_transfer();
        bit          broken;
        bit          rd;
        int          fail_in;
        int          polls;
        int          eff_lim;
        int          nab;
        logic [15:0] len;
        eff_lim = (cfg_plimit == 16'd0) ? 1 : int'(cfg_plimit);
        nab     = (cfg_abytes == 2'd1) ? 1 : 2;
        broken  = ($urandom_range(0, 99) < 30);
        rd      = 1'($urandom);
        // long transfers only when a missing ack is planned to cut them short
        if (broken) len = 16'($urandom);
        else if ($urandom_range(0, 99) < 85) len = 16'($urandom_range(0, 6));
        else len = 16'($urandom_range(7, 24));
        if (!broken) fail_in = -1;
        else if (rd) fail_in = $urandom_range(0, nab + 1);
        else fail_in = $urandom_range(0, 12);
        if (eff_lim <= 4 && $urandom_range(0, 99) < 15) polls = eff_lim;
        else polls = $urandom_range(0, (eff_lim > 3) ? 2 : eff_lim - 1);
        if (rd) do_read(16'($urandom), len, fail_in);
        else do_write(16'($urandom), len, fail_in, polls);
    endtask

    initial begin
        int start;
        int ph;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed, reset register values
        do_read(16'h0000, 16'd1, -1);
        do_read(16'hFFFF, 16'd0, -1);
        do_write(16'h1234, 16'd0, -1, 0);
        do_write(16'hFFFF, 16'd2, -1, 1);
        do_write(16'h0010, 16'd3, 3, 0);
        do_read(16'h5A5A, 16'hFFFF, 0);
        for (int c = int'(CMD_ACK_RESP); c < 8; c++) send_item(rand_item(3'(c)));

        noise_pct = 8;
        start     = real_beats;
        ph        = 0;
        while (real_beats - start < RANDOM_BEATS) begin
            in_valid <= 1'b0;
            settle();
            case (ph)
                0: load_config(8'hFF, 2'd1, 4'd0, 16'd1);
                1: load_config(8'h00, 2'd2, 4'd10, 16'hFFFF);
                2: load_config(8'hA6, 2'd3, 4'd2, 16'd3);
                3: load_config(8'h5B, 2'd0, 4'd15, 16'd0);
                default: load_config(8'($urandom), 2'($urandom_range(1, 2)),
                                     4'($urandom_range(0, 4)), 16'($urandom_range(1, 4)));
            endcase
            calm = (ph == 2);
            while (real_beats - start < PHASE_BEATS * (ph + 1)) random_transfer();
            ph++;
        end
        calm = 1'b0;

        in_valid <= 1'b0;
        settle();
        if (fails == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/ieeseq_pkg.sv
hdl/ieeseq_front.sv
hdl/ieeseq_queue.sv
hdl/ieeseq_back.sv
hdl/i2c_eeprom_transaction_sequencer.sv
tb/ieeseq_checker.sv
tb/tb_i2c_eeprom_transaction_sequencer.sv
